// ===== rtl/core/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// shared sizes, request and status codes for the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DQ_DEPTH = 16;
    localparam int DQ_AW    = (DQ_DEPTH > 1) ? $clog2(DQ_DEPTH) : 1;
    localparam int DQ_CW    = $clog2(DQ_DEPTH + 1);
    localparam int DQ_SW    = DQ_CW + 1;

    localparam int DQ_DATA_W    = 32;
    localparam int DQ_ENTRIES_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // fold a sum below twice the depth back into the ring
    function automatic logic [DQ_AW-1:0] dq_wrap(input logic [DQ_SW-1:0] s);
        logic [DQ_SW-1:0] r;
        begin
            if (s >= DQ_SW'(DQ_DEPTH))
            begin
                r = s - DQ_SW'(DQ_DEPTH);
            end
            else
            begin
                r = s;
            end
            return DQ_AW'(r);
        end
    endfunction

endpackage

// ===== rtl/core/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// sequence: a transaction taken by start is followed by the read of the ring
// memory in S_READ (busy high), then by its result in S_RESP (done high)
// start is ignored while busy, so a transaction may be taken while done is
// high, before the last one is through
// reset: rst_n clears head, count and control; the ring memory is not cleared
// the receiver cannot stall, results appear on done for one cycle
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic [dq_pkg::DQ_DATA_W-1:0] value_in,
    output logic                         done,
    output logic [dq_pkg::DQ_DATA_W-1:0] front_value,
    output logic [dq_pkg::DQ_DATA_W-1:0] back_value,
    output logic [dq_pkg::DQ_ENTRIES_W-1:0] entries_held,
    output logic                         is_empty,
    output logic [1:0]                   status
);
    import dq_pkg::*;

    // one-hot sequencer: take request, read ring, present result
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [DQ_AW-1:0]     head_reg, head_next;
    logic [DQ_CW-1:0]     count_reg, count_next;
    status_t              status_reg, status_next;

    // ring memory, one write port and two registered read ports
    logic [DQ_DATA_W-1:0] ring_mem [DQ_DEPTH];
    logic [DQ_DATA_W-1:0] rd_front_reg;
    logic [DQ_DATA_W-1:0] rd_back_reg;

    logic                 accept;
    logic                 full;
    logic                 none;
    logic                 wr_en;
    logic [DQ_AW-1:0]     wr_addr;
    logic [DQ_AW-1:0]     back_addr;
    req_t                 req;

    assign busy   = (state_reg == S_READ);
    assign accept = start && !busy;
    assign req    = req_t'(req_type);
    assign full   = (count_reg == DQ_CW'(DQ_DEPTH));
    assign none   = (count_reg == '0);

    // request decode: pointer and count update plus the memory write
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        wr_en       = 1'b0;
        wr_addr     = head_reg;
        unique case (req)
            REQ_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    // step head back one slot, wrapping below zero
                    if (head_reg == '0)
                    begin
                        head_next = DQ_AW'(DQ_DEPTH - 1);
                    end
                    else
                    begin
                        head_next = head_reg - DQ_AW'(1);
                    end
                    wr_en      = 1'b1;
                    wr_addr    = head_next;
                    count_next = count_reg + DQ_CW'(1);
                end
            end
            REQ_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = dq_wrap(DQ_SW'(head_reg) + DQ_SW'(count_reg));
                    count_next = count_reg + DQ_CW'(1);
                end
            end
            REQ_POP_FRONT:
            begin
                if (none)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    head_next  = dq_wrap(DQ_SW'(head_reg) + DQ_SW'(1));
                    count_next = count_reg - DQ_CW'(1);
                end
            end
            REQ_POP_BACK:
            begin
                if (none)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - DQ_CW'(1);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // a new transaction may start while the result is shown
                state_next = accept ? S_READ : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                head_reg   <= head_next;
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    // back entry sits at head + count - 1; meaningless when empty, masked below
    assign back_addr = dq_wrap(DQ_SW'(head_reg) + DQ_SW'(count_reg) - DQ_SW'(1));

    // write at acceptance, read both ends in the next cycle (S_READ), so no forwarding
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            ring_mem[wr_addr] <= value_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_front_reg <= ring_mem[head_reg];
            rd_back_reg  <= ring_mem[back_addr];
        end
    end

    // result ports
    assign done         = (state_reg == S_RESP);
    assign is_empty     = none;
    assign front_value  = none ? '0 : rd_front_reg;
    assign back_value   = none ? '0 : rd_back_reg;
    assign entries_held = DQ_ENTRIES_W'(count_reg);
    assign status       = status_reg;

endmodule

// ===== rtl/core/dq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker
// port-level checks of the queue sequencing and result consistency
// ----------------------------------------------------------------------------
module dq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [dq_pkg::DQ_DATA_W-1:0]    front_value,
    input logic [dq_pkg::DQ_DATA_W-1:0]    back_value,
    input logic                            is_empty,
    input logic [1:0]                      status
);
    import dq_pkg::*;

    // a taken transaction occupies the memory read slot next
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not enter read cycle");

    // every read cycle is followed by a result
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("read cycle not followed by result");

    // a result never shows while the read slot is taken
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result and read cycle overlap");

    // empty queue reports zero values
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_empty |-> (front_value == '0) && (back_value == '0))
        else $error("empty queue reported nonzero values");

    // underflow leaves the queue empty
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_UNDERFLOW) |-> is_empty)
        else $error("underflow reported on nonempty queue");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .front_value (front_value),
    .back_value  (back_value),
    .is_empty    (is_empty),
    .status      (status)
);
